>>> hdl/cnls_pkg.sv
// ----------------------------------------------------------------------------
// cnls_pkg
// Types, codes and command tables shared by the nibble sequencer modules.
// ----------------------------------------------------------------------------
package cnls_pkg;

	localparam int ADDR_W  = 5;
	localparam int DATA_W  = 32;
	localparam int REG_W   = 20;
	localparam int WAIT_W  = 21;
	localparam int STEP_W  = 5;

	// request codes on the action field
	typedef enum logic [1:0] {
		ACT_INIT  = 2'd0,
		ACT_CHAR  = 2'd1,
		ACT_POS   = 2'd2,
		ACT_CLEAR = 2'd3
	} action_t;

	// register index (paddr[4:2])
	typedef enum logic [2:0] {
		REG_POWER_UP = 3'd0,
		REG_COMMAND  = 3'd1,
		REG_CLEAR    = 3'd2,
		REG_CHAR     = 3'd3,
		REG_POSITION = 3'd4
	} reg_idx_t;

	// extra wait selection for single-byte requests
	typedef enum logic [1:0] {
		WSEL_NONE = 2'd0,
		WSEL_CHAR = 2'd1,
		WSEL_POS  = 2'd2
	} wsel_t;

	localparam logic [7:0] CMD_CLEAR     = 8'h01;
	localparam logic [7:0] CMD_SET_DDRAM = 8'h80;
	localparam logic [6:0] ROW1_OFFSET   = 7'h40;
	localparam logic [1:0] ROW_SECOND    = 2'd1;
	localparam logic [3:0] NIB_MASK      = 4'hF;

	// init: step 0 is the pin-low wait, steps 1..16 the eight words
	localparam logic [STEP_W-1:0] INIT_LAST_STEP = 5'd16;
	localparam logic [2:0]        IW_FIRST       = 3'd0;
	localparam logic [2:0]        IW_CLEAR       = 3'd4;

	localparam logic [REG_W-1:0] RST_POWER_UP = 20'd20000;
	localparam logic [REG_W-1:0] RST_COMMAND  = 20'd20;
	localparam logic [REG_W-1:0] RST_CLEAR    = 20'd900;
	localparam logic [REG_W-1:0] RST_CHAR     = 20'd2000;
	localparam logic [REG_W-1:0] RST_POSITION = 20'd20000;

	typedef struct packed {
		logic [REG_W-1:0] power_up;
		logic [REG_W-1:0] command;
		logic [REG_W-1:0] clear;
		logic [REG_W-1:0] char_w;
		logic [REG_W-1:0] position;
	} cfg_t;

	// one classified request between front and back
	typedef struct packed {
		logic       is_init;
		logic       rs;
		logic [7:0] data;
		wsel_t      wsel;
	} entry_t;

	function automatic logic [7:0] init_word(input logic [2:0] idx);
		logic [7:0] w;
		case (idx)
			3'd0:    w = 8'h33;
			3'd1:    w = 8'h32;
			3'd2:    w = 8'h28;
			3'd3:    w = 8'h08;
			3'd4:    w = 8'h01;
			3'd5:    w = 8'h06;
			3'd6:    w = 8'h0C;
			3'd7:    w = 8'h02;
			default: w = 8'h00;
		endcase
		return w;
	endfunction

endpackage

>>> hdl/char_lcd_nibble_sequencer.sv
// ----------------------------------------------------------------------------
// char_lcd_nibble_sequencer
// Character LCD request to 4-bit bus transfer sequencer with APB registers.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall, fields action, char_code, row, col)
//   takes one request per transfer. Output channel (out_valid/out_stall)
//   gives one bus transfer per cycle while work is queued and unstalled:
//   strobe_res, reg_select, nibble, wait_after_us, with last on the final
//   transfer of each request. Write character, set position and clear give
//   2 transfers; init gives 17 (a pin-low power-up wait, then 8 command
//   words as nibble pairs). The single transfer sequencer in the back sets
//   this rate. The first transfer of a request passes the input register,
//   the queue and the output register. The front registers and classifies
//   requests into a QUEUE_DEPTH FIFO; in_stall rises only when that FIFO
//   and the input register are full. A stalled output transfer holds; the
//   sequencer pauses, the front keeps accepting until the queue fills.
//   Reset (arst_n low) empties the queue and output, and loads the wait
//   registers with their defaults. The user must write registers over APB
//   only while idle; the block itself does not enforce this. Reads return
//   the stored 20-bit value.
// ----------------------------------------------------------------------------
module char_lcd_nibble_sequencer import cnls_pkg::*; #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	// APB register port
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	// request channel
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        action,
	input  logic [7:0]        char_code,
	input  logic [1:0]        row,
	input  logic [5:0]        col,
	// transfer channel
	output logic              out_valid,
	input  logic              out_stall,
	output logic              strobe_res,
	output logic              reg_select,
	output logic [3:0]        nibble,
	output logic [WAIT_W-1:0] wait_after_us,
	output logic              last
);

	cfg_t     cfg_q;
	reg_idx_t widx;
	logic     wr_en;

	logic   push;
	entry_t push_entry;
	logic   q_full;
	logic   q_empty;
	logic   pop;
	entry_t head;

	// register file: index from word address, low 20 bits kept
	assign pready = 1'b1;
	assign widx   = reg_idx_t'(paddr[4:2]);
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.power_up <= RST_POWER_UP;
			cfg_q.command  <= RST_COMMAND;
			cfg_q.clear    <= RST_CLEAR;
			cfg_q.char_w   <= RST_CHAR;
			cfg_q.position <= RST_POSITION;
		end else if (wr_en) begin
			case (widx)
				REG_POWER_UP: cfg_q.power_up <= pwdata[REG_W-1:0];
				REG_COMMAND:  cfg_q.command  <= pwdata[REG_W-1:0];
				REG_CLEAR:    cfg_q.clear    <= pwdata[REG_W-1:0];
				REG_CHAR:     cfg_q.char_w   <= pwdata[REG_W-1:0];
				REG_POSITION: cfg_q.position <= pwdata[REG_W-1:0];
				default: ;    // outside the map: ignored
			endcase
		end
	end

	always_comb begin
		case (widx)
			REG_POWER_UP: prdata = DATA_W'(cfg_q.power_up);
			REG_COMMAND:  prdata = DATA_W'(cfg_q.command);
			REG_CLEAR:    prdata = DATA_W'(cfg_q.clear);
			REG_CHAR:     prdata = DATA_W'(cfg_q.char_w);
			REG_POSITION: prdata = DATA_W'(cfg_q.position);
			default:      prdata = '0;
		endcase
	end

	cnls_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.action     (action),
		.char_code  (char_code),
		.row        (row),
		.col        (col),
		.push       (push),
		.push_entry (push_entry),
		.q_full     (q_full)
	);

	cnls_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.empty      (q_empty),
		.head       (head)
	);

	cnls_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.empty         (q_empty),
		.head          (head),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.strobe_res    (strobe_res),
		.reg_select    (reg_select),
		.nibble        (nibble),
		.wait_after_us (wait_after_us),
		.last          (last)
	);

endmodule

>>> hdl/cnls_front.sv
// ----------------------------------------------------------------------------
// cnls_front
// Input stage: registers a request and classifies it into a queue entry.
// ----------------------------------------------------------------------------
module cnls_front import cnls_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_stall,
	input  logic [1:0]   action,
	input  logic [7:0]   char_code,
	input  logic [1:0]   row,
	input  logic [5:0]   col,
	output logic         push,
	output entry_t       push_entry,
	input  logic         q_full
);

	logic   valid_s1;
	entry_t entry_s1;
	entry_t cls;
	logic   accept;
	logic [6:0] pos;

	always_comb begin
		pos = (row == ROW_SECOND) ? (ROW1_OFFSET + {1'b0, col}) : {1'b0, col};
		cls = '{is_init: 1'b0, rs: 1'b0, data: CMD_CLEAR, wsel: WSEL_NONE};
		case (action_t'(action))
			ACT_INIT: begin
				cls.is_init = 1'b1;
			end
			ACT_CHAR: begin
				cls.rs   = 1'b1;
				cls.data = char_code;
				cls.wsel = WSEL_CHAR;
			end
			ACT_POS: begin
				cls.data = CMD_SET_DDRAM | {1'b0, pos};
				cls.wsel = WSEL_POS;
			end
			default: begin
				cls.data = CMD_CLEAR;
			end
		endcase
	end

	assign push       = valid_s1 && !q_full;
	assign in_stall   = valid_s1 && q_full;
	assign accept     = in_valid && !in_stall;
	assign push_entry = entry_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			entry_s1 <= cls;
		end
	end

endmodule

>>> hdl/cnls_queue.sv
// ----------------------------------------------------------------------------
// cnls_queue
// Small FIFO of classified requests; head is shown without a read cycle.
// ----------------------------------------------------------------------------
module cnls_queue import cnls_pkg::*; #(
	parameter int DEPTH = 2  // at least 2
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_entry,
	output logic   full,
	input  logic   pop,
	output logic   empty,
	output entry_t head
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	entry_t        mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	function automatic logic [PW-1:0] nxt(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= nxt(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= nxt(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

>>> hdl/cnls_back.sv
// ----------------------------------------------------------------------------
// cnls_back
// Transfer sequencer: steps through the queue head and fills the output
// register, one transfer per cycle unless stalled or the queue is empty.
// ----------------------------------------------------------------------------
module cnls_back import cnls_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic              empty,
	input  entry_t            head,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              strobe_res,
	output logic              reg_select,
	output logic [3:0]        nibble,
	output logic [WAIT_W-1:0] wait_after_us,
	output logic              last
);

	logic [STEP_W-1:0] step_q;
	logic [STEP_W-1:0] step_m1;
	logic              out_valid_q;
	logic              fire;

	logic              t_strobe;
	logic              t_rs;
	logic [3:0]        t_nib;
	logic [WAIT_W-1:0] t_wait;
	logic              t_last;
	logic [7:0]        byte_v;
	logic              low;
	logic [REG_W-1:0]  extra;
	logic [2:0]        widx;

	assign fire = !empty && (!out_valid_q || !out_stall);
	assign pop  = fire && t_last;

	always_comb begin
		step_m1 = step_q - 1'b1;
		widx    = step_m1[3:1];
		byte_v  = head.data;
		low     = step_q[0];
		t_last  = low;
		t_strobe = 1'b1;
		t_rs    = head.rs;
		case (head.wsel)
			WSEL_CHAR: extra = cfg.char_w;
			WSEL_POS:  extra = cfg.position;
			default:   extra = '0;
		endcase
		if (head.is_init) begin
			byte_v = init_word(widx);
			low    = step_m1[0];
			t_last = (step_q == INIT_LAST_STEP);
			t_rs   = 1'b0;
			if (widx == IW_FIRST) begin
				extra = cfg.power_up;
			end else if (widx == IW_CLEAR) begin
				extra = cfg.clear;
			end else begin
				extra = cfg.command;
			end
		end
		t_nib  = low ? (byte_v[3:0] & NIB_MASK) : byte_v[7:4];
		t_wait = low ? (WAIT_W'(1) + {1'b0, extra}) : WAIT_W'(1);
		// power-up pin-low wait opens the init run
		if (head.is_init && step_q == '0) begin
			t_strobe = 1'b0;
			t_rs     = 1'b0;
			t_nib    = '0;
			t_wait   = {1'b0, cfg.power_up};
			t_last   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				step_q <= t_last ? '0 : step_q + 1'b1;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			strobe_res    <= t_strobe;
			reg_select    <= t_rs;
			nibble        <= t_nib;
			wait_after_us <= t_wait;
			last          <= t_last;
		end
	end

	assign out_valid = out_valid_q;

endmodule

>>> hdl/cnls_checker.sv
// ----------------------------------------------------------------------------
// cnls_checker
// Port-level checks for the nibble sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module cnls_checker import cnls_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_stall,
	input logic              strobe_res,
	input logic              reg_select,
	input logic [3:0]        nibble,
	input logic [WAIT_W-1:0] wait_after_us,
	input logic              last
);

	// stalled transfer holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(nibble) && $stable(wait_after_us)
			&& $stable(last) && $stable(strobe_res))
		else $error("stalled transfer changed");

	// pin-low wait drives command register and zero data
	a_pinlow: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !strobe_res |-> !reg_select && nibble == 4'h0)
		else $error("pin-low wait with data");

	// pin-low wait never closes a request
	a_pinlow_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !strobe_res |-> !last)
		else $error("pin-low wait marked last");

	// within a request transfers follow without a gap
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last |=> out_valid)
		else $error("gap inside a request");

endmodule

bind char_lcd_nibble_sequencer cnls_checker u_cnls_checker (.*);

>>> dv/char_lcd_nibble_sequencer_checker.sv
// ----------------------------------------------------------------------------
// char_lcd_nibble_sequencer_checker
// Watches the register port and both channels, predicts the bus transfers of
// every accepted request and compares them in order against the block.
// ----------------------------------------------------------------------------
module char_lcd_nibble_sequencer_checker import cnls_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic              pready,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic [1:0]        action,
	input  logic [7:0]        char_code,
	input  logic [1:0]        row,
	input  logic [5:0]        col,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic              strobe_res,
	input  logic              reg_select,
	input  logic [3:0]        nibble,
	input  logic [WAIT_W-1:0] wait_after_us,
	input  logic              last,
	output int                errors,
	output int                pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int         INIT_WORDS   = 8;
	localparam int         POWER_WORD   = 0;
	localparam int         CLEAR_WORD   = 4;
	localparam logic [63:0] INIT_SEQ    = {8'h33, 8'h32, 8'h28, 8'h08,
		8'h01, 8'h06, 8'h0C, 8'h02};
	localparam logic [7:0] SET_ADDR     = 8'h80;
	localparam logic [7:0] CLEAR_CMD    = 8'h01;
	localparam logic [6:0] SECOND_BASE  = 7'h40;
	localparam logic [1:0] SECOND_ROW   = 2'd1;
	localparam int         PRINT_CAP    = 40;

	typedef struct packed {
		logic              strobe;
		logic              rs;
		logic [3:0]        nib;
		logic [WAIT_W-1:0] wait_us;
		logic              fin;
	} bus_xfer_t;

	bus_xfer_t bus_xfers_q [$];

	logic [REG_W-1:0] power_up_us, command_us, clear_us, char_us, position_us;

	task automatic report_mismatch(input string msg);
		if (errors < PRINT_CAP)
			$display("[%0t] lcd transfer mismatch: %s", $realtime, msg);
		errors++;
	endtask

	function automatic bus_xfer_t make_xfer(input logic strobe, input logic rs,
			input logic [3:0] nib, input logic [WAIT_W-1:0] w, input logic fin);
		bus_xfer_t x;
		x.strobe  = strobe;
		x.rs      = rs;
		x.nib     = nib;
		x.wait_us = w;
		x.fin     = fin;
		return x;
	endfunction

	// high nibble with 1 us, low nibble with 1 us plus the byte's extra wait
	task automatic push_byte(input logic rs, input logic [7:0] data,
			input logic [REG_W-1:0] extra, input logic fin);
		bus_xfers_q.push_back(make_xfer(1'b1, rs, data[7:4], WAIT_W'(1), 1'b0));
		bus_xfers_q.push_back(make_xfer(1'b1, rs, data[3:0],
			WAIT_W'(extra) + WAIT_W'(1), fin));
	endtask

	task automatic push_request_xfers(input action_t act, input logic [7:0] ch,
			input logic [1:0] r, input logic [5:0] c);
		logic [REG_W-1:0] extra;
		logic [6:0]       pos;
		case (act)
			ACT_INIT: begin
				bus_xfers_q.push_back(make_xfer(1'b0, 1'b0, 4'h0,
					WAIT_W'(power_up_us), 1'b0));
				for (int i = 0; i < INIT_WORDS; i++) begin
					if (i == POWER_WORD)
						extra = power_up_us;
					else if (i == CLEAR_WORD)
						extra = clear_us;
					else
						extra = command_us;
					push_byte(1'b0, INIT_SEQ[8*(INIT_WORDS-1-i) +: 8], extra,
						i == INIT_WORDS - 1);
				end
			end
			ACT_CHAR: push_byte(1'b1, ch, char_us, 1'b1);
			ACT_POS: begin
				pos = (r == SECOND_ROW) ? SECOND_BASE + 7'(c) : 7'(c);
				push_byte(1'b0, SET_ADDR | {1'b0, pos}, position_us, 1'b1);
			end
			default: push_byte(1'b0, CLEAR_CMD, '0, 1'b1);
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		bus_xfer_t seen, want;
		if (!arst_n) begin
			power_up_us = RST_POWER_UP;
			command_us  = RST_COMMAND;
			clear_us    = RST_CLEAR;
			char_us     = RST_CHAR;
			position_us = RST_POSITION;
			bus_xfers_q.delete();
			errors = 0;
			pending <= 0;
		end else begin
			// register writes land at the access edge; spare addresses ignored
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[ADDR_W-1:2]))
					REG_POWER_UP: power_up_us = pwdata[REG_W-1:0];
					REG_COMMAND:  command_us  = pwdata[REG_W-1:0];
					REG_CLEAR:    clear_us    = pwdata[REG_W-1:0];
					REG_CHAR:     char_us     = pwdata[REG_W-1:0];
					REG_POSITION: position_us = pwdata[REG_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				push_request_xfers(action_t'(action), char_code, row, col);
			if (out_valid && !out_stall) begin
				seen = make_xfer(strobe_res, reg_select, nibble, wait_after_us, last);
				if (bus_xfers_q.size() == 0) begin
					report_mismatch($sformatf("unexpected transfer %p", seen));
				end else begin
					want = bus_xfers_q.pop_front();
					if (seen.strobe !== want.strobe)
						report_mismatch($sformatf("strobe_res got %0h want %0h",
							seen.strobe, want.strobe));
					if (seen.rs !== want.rs)
						report_mismatch($sformatf("reg_select got %0h want %0h",
							seen.rs, want.rs));
					if (seen.nib !== want.nib)
						report_mismatch($sformatf("nibble got %0h want %0h",
							seen.nib, want.nib));
					if (seen.wait_us !== want.wait_us)
						report_mismatch($sformatf("wait_after_us got %0d want %0d",
							seen.wait_us, want.wait_us));
					if (seen.fin !== want.fin)
						report_mismatch($sformatf("last got %0h want %0h",
							seen.fin, want.fin));
				end
			end
			pending <= bus_xfers_q.size();
		end
	end

endmodule

>>> dv/char_lcd_nibble_sequencer_tb.sv
// ----------------------------------------------------------------------------
// char_lcd_nibble_sequencer_tb
// Drives LCD requests and wait register settings into the nibble sequencer,
// with bursty input, random output stalls and a long output hold-off; the
// checker beside the block predicts and compares every bus transfer.
// ----------------------------------------------------------------------------
module char_lcd_nibble_sequencer_tb import cnls_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	// slowest run: ~200 requests, all init (17 transfers), heavy stalls,
	// gaps and hold-offs stay far below this
	localparam int CYCLE_LIMIT     = 300000;
	localparam int HOLD_OFF_CYCLES = 150;
	localparam int RANDOM_PER_PASS = 45;
	localparam int NUM_WAIT_REGS   = 5;
	localparam int NUM_REG_SLOTS   = 1 << $bits(reg_idx_t);
	localparam int SETTLE_CYCLES   = 8;

	logic              clk;
	logic              arst_n;
	logic              psel, penable, pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              in_valid, in_stall;
	logic [1:0]        action;
	logic [7:0]        char_code;
	logic [1:0]        row;
	logic [5:0]        col;
	logic              out_valid, out_stall;
	logic              strobe_res, reg_select, last;
	logic [3:0]        nibble;
	logic [WAIT_W-1:0] wait_after_us;
	int                errors, pending;

	// hold-off handshake between stimulus and the receiver process
	int holds_asked  = 0;
	int holds_served = 0;
	// sender burst bookkeeping
	int burst_left   = 0;

	char_lcd_nibble_sequencer dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall), .action(action),
		.char_code(char_code), .row(row), .col(col),
		.out_valid(out_valid), .out_stall(out_stall), .strobe_res(strobe_res),
		.reg_select(reg_select), .nibble(nibble), .wait_after_us(wait_after_us),
		.last(last)
	);

	char_lcd_nibble_sequencer_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata),
		.in_valid(in_valid), .in_stall(in_stall), .action(action),
		.char_code(char_code), .row(row), .col(col),
		.out_valid(out_valid), .out_stall(out_stall), .strobe_res(strobe_res),
		.reg_select(reg_select), .nibble(nibble), .wait_after_us(wait_after_us),
		.last(last),
		.errors(errors), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: a hung handshake or a lost transfer ends up here.
	initial begin
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("[char_lcd_nibble_sequencer] ERROR");
		$finish;
	end

	// Receiver: random stall segments of random style; a pending hold-off
	// request parks the output for a long stretch so the front queue fills
	// and in_stall must rise while the sender keeps offering.
	initial begin
		int  seg_len;
		int  mode;
		bit  flip;
		flip = 1'b0;
		out_stall <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (holds_served < holds_asked) begin
				holds_served++;
				out_stall <= 1'b1;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end
			seg_len = $urandom_range(1, 40);
			mode    = $urandom_range(0, 3);
			repeat (seg_len) begin
				case (mode)
					0: out_stall <= 1'b0;                       // free running
					1: out_stall <= ($urandom_range(0, 3) == 0); // light stalls
					2: out_stall <= ($urandom_range(0, 3) != 0); // heavy stalls
					default: begin                              // alternating stalls
						flip = ~flip;
						out_stall <= flip;
					end
				endcase
				@(posedge clk);
			end
		end
	end

	// APB write: setup cycle, access cycle (write lands here since pready is
	// tied high), then an idle cycle so back-to-back writes never drop and
	// raise psel in the same step.
	task automatic write_wait_reg(input logic [2:0] idx, input logic [DATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// Program all five wait registers, plus junk into the unused addresses,
	// which the block must ignore.
	task automatic program_waits(input logic [DATA_W-1:0] pu, input logic [DATA_W-1:0] cmd,
			input logic [DATA_W-1:0] clr, input logic [DATA_W-1:0] chr,
			input logic [DATA_W-1:0] pos);
		write_wait_reg(REG_POWER_UP, pu);
		write_wait_reg(REG_COMMAND,  cmd);
		write_wait_reg(REG_CLEAR,    clr);
		write_wait_reg(REG_CHAR,     chr);
		write_wait_reg(REG_POSITION, pos);
		for (int i = NUM_WAIT_REGS; i < NUM_REG_SLOTS; i++)
			write_wait_reg(3'(i), $urandom);
	endtask

	// Offer one request and hold it until the transfer happens. Bursts of
	// random length run back to back; between bursts valid drops for a
	// random gap (sometimes zero).
	task automatic send_request(input action_t act, input logic [7:0] ch,
			input logic [1:0] r, input logic [5:0] c);
		int gap;
		action    <= act;
		char_code <= ch;
		row       <= r;
		col       <= c;
		in_valid  <= 1'b1;
		do @(posedge clk); while (in_stall);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 12);
			gap        = $urandom_range(0, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Init is rare in real use but the longest sequence, so give it a fair
	// share; all fields are random regardless of which ones the action uses.
	task automatic send_random_request();
		int     pick;
		action_t act;
		pick = $urandom_range(0, 99);
		if (pick < 12)
			act = ACT_INIT;
		else if (pick < 52)
			act = ACT_CHAR;
		else if (pick < 87)
			act = ACT_POS;
		else
			act = ACT_CLEAR;
		send_request(act, 8'($urandom), 2'($urandom), 6'($urandom));
	endtask

	// Wait until the checker holds no expectation, then let the outputs settle.
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic random_pass(input bit with_hold);
		for (int i = 0; i < RANDOM_PER_PASS; i++) begin
			if (with_hold && i == RANDOM_PER_PASS / 3)
				holds_asked++;
			send_random_request();
		end
	endtask

	initial begin
		arst_n    <= 1'b0;
		psel      <= 1'b0;
		penable   <= 1'b0;
		pwrite    <= 1'b0;
		paddr     <= '0;
		pwdata    <= '0;
		in_valid  <= 1'b0;
		action    <= ACT_INIT;
		char_code <= '0;
		row       <= '0;
		col       <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, at reset wait values: every action, character byte
		// extremes, every row (second line offset vs. pass-through rows 0/2/3)
		// and column extremes past the visible display.
		send_request(ACT_INIT,  8'($urandom), 2'($urandom), 6'($urandom));
		send_request(ACT_CHAR,  8'h00, 2'($urandom), 6'($urandom));
		send_request(ACT_CHAR,  8'hFF, 2'($urandom), 6'($urandom));
		send_request(ACT_CHAR,  8'hA5, 2'($urandom), 6'($urandom));
		send_request(ACT_POS,   8'($urandom), 2'd0, 6'd0);
		send_request(ACT_POS,   8'($urandom), 2'd1, 6'd63);
		send_request(ACT_POS,   8'($urandom), 2'd2, 6'h2A);
		send_request(ACT_POS,   8'($urandom), 2'd3, 6'h15);
		send_request(ACT_POS,   8'($urandom), 2'd1, 6'd0);
		send_request(ACT_POS,   8'($urandom), 2'd0, 6'd63);
		send_request(ACT_CLEAR, 8'($urandom), 2'($urandom), 6'($urandom));
		send_request(ACT_CHAR,  8'h5A, 2'($urandom), 6'($urandom));
		send_request(ACT_INIT,  8'($urandom), 2'($urandom), 6'($urandom));
		send_request(ACT_CLEAR, 8'($urandom), 2'($urandom), 6'($urandom));
		drain();

		// all waits zero: low nibble carries just the 1 us
		program_waits('0, '0, '0, '0, '0);
		random_pass(1'b0);
		drain();

		// all ones: only the low 20 bits stick, wait tops out at 2^20
		program_waits('1, '1, '1, '1, '1);
		random_pass(1'b1);
		drain();

		// full random words, upper bits dropped by the block
		program_waits($urandom, $urandom, $urandom, $urandom, $urandom);
		random_pass(1'b1);
		drain();

		// tiny waits
		program_waits($urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 3),
			$urandom_range(0, 3), $urandom_range(0, 3));
		random_pass(1'b0);
		drain();

		if (errors == 0)
			$display("[char_lcd_nibble_sequencer] OK");
		else
			$display("[char_lcd_nibble_sequencer] ERROR");
		$finish;
	end

endmodule

>>> char_lcd_nibble_sequencer.f
hdl/cnls_pkg.sv
hdl/cnls_front.sv
hdl/cnls_queue.sv
hdl/cnls_back.sv
hdl/char_lcd_nibble_sequencer.sv
hdl/cnls_checker.sv
dv/char_lcd_nibble_sequencer_checker.sv
dv/char_lcd_nibble_sequencer_tb.sv
